// ===== rtl/core/view_frustum_culling_test_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the view frustum culling block
// Short forms for the clocked, reset-qualified properties used at the top level.
// ----------------------------------------------------------------------------
`ifndef VIEW_FRUSTUM_CULLING_TEST_TOP_ASSERT_SVH
`define VIEW_FRUSTUM_CULLING_TEST_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define VFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define VFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants and helpers of the view frustum culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  // Default number of fraction bits in coordinates and plane offsets.
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  // The frustum always has six planes.
  localparam int unsigned PLANE_COUNT = 6;

  // Command codes.
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_PLANES = 3'd1;
  localparam logic [2:0] MODE_POINT  = 3'd2;
  localparam logic [2:0] MODE_SPHERE = 3'd3;
  localparam logic [2:0] MODE_CUBE   = 3'd4;
  localparam logic [2:0] MODE_BOX    = 3'd5;

  // Largest positive plane word.
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  // Matrix column combined with the w column for a plane.
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    return p[2:1];
  endfunction

  // Whether a plane adds (1) or subtracts (0) that column.
  function automatic logic plane_add(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // Saturates an unsigned quotient to 31 bits and applies the sign.
  function automatic logic [31:0] with_sign(input logic [63:0] q, input logic neg);
    logic [31:0] m;
    m = (|q[63:31]) ? {1'b0, MAG_MAX} : {1'b0, q[30:0]};
    return neg ? (32'd0 - m) : m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/view_frustum_culling_test_top.sv =====
// ----------------------------------------------------------------------------
// view_frustum_culling_test_top
// Frustum plane extraction from a clip matrix and point, sphere, cube and box culling.
// ----------------------------------------------------------------------------
// A command is transferred when start_i is high and busy_o is low. Each command
// gives one result on inside_res_o and is_test_o, marked by done_o for one cycle.
// The receiver cannot stall; results are never held back.
// Loads and unused codes are answered from idle and leave busy_o low.
// A compute command sweeps the six planes: per plane it forms the row sums and
// takes magnitudes; unless the normal is zero it then applies the normalizing
// shift, forms the squared length and takes the root, and it runs up to four
// divisions with a prepare and a write step each; the block has one shared
// multiplier and takes one square root step and one divider bit each cycle.
// A test runs each plane and corner through the shared multiplier: point and
// sphere test one corner a plane, cube and box up to eight, fewer on early exit.
// Reset loads the identity matrix and clears every plane to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module view_frustum_culling_test_top
  import vfc_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic [3:0]         elem_index_i,
  input  wire logic signed [31:0] elem_value_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] far_x_i,
  input  wire logic signed [31:0] far_y_i,
  input  wire logic signed [31:0] far_z_i,
  input  wire logic [30:0]        extent_i,
  output logic                    done_o,
  output logic                    inside_res_o,
  output logic                    is_test_o
);

  localparam logic [31:0] FX_ONE = 32'd1 << COORD_FRAC_BITS;
  localparam int unsigned SH_W   = $clog2(COORD_FRAC_BITS + 31);
  localparam int unsigned SHW    = 64 + COORD_FRAC_BITS + 30;
  localparam int unsigned ACC_W  = 67;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FORM  = 4'd1;
  localparam logic [3:0] S_MAG   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_SQMUL = 4'd4;
  localparam logic [3:0] S_SQACC = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DPREP = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DWR   = 4'd9;
  localparam logic [3:0] S_TINIT = 4'd10;
  localparam logic [3:0] S_TMUL  = 4'd11;
  localparam logic [3:0] S_TACC  = 4'd12;
  localparam logic [3:0] S_TCHK  = 4'd13;

  // Stores and control state.
  logic [31:0] mstore_q [16];
  logic [31:0] pstore_q [24];
  logic [3:0]  state_q, state_d;
  logic [2:0]  plane_q, plane_d;
  logic [1:0]  j_q, j_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [2:0]  corner_q, corner_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        multi_q, multi_d;
  logic        done_q, done_d;
  logic        inside_q, inside_d;
  logic        is_test_q, is_test_d;

  // Datapath registers.
  logic [31:0]        w_q;
  logic signed [32:0] v_q [4];
  logic [32:0]        s_q [3];
  logic               zero_q;
  logic [SH_W-1:0]    sh_q;
  logic [63:0]        sq_n_q;
  logic [63:0]        r_q;
  logic [63:0]        bit_q;
  logic [63:0]        num_q;
  logic [32:0]        rem_q;
  logic signed [65:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [32:0] lo_q [3];
  logic signed [32:0] hi_q [3];
  logic [30:0]        bias_q;

  logic        accept;
  logic        mat_we;
  logic        pl_we;
  logic [31:0] pl_wdata;
  logic        wr_fin;

  assign accept = start_i && (state_q == S_IDLE);

  // Store reads.
  logic [3:0]  mat_idx;
  logic [31:0] mat_rd;
  logic [4:0]  pl_idx;
  logic [31:0] pl_rd;

  assign mat_idx = fcnt_q[0] ? {fcnt_q[2:1], plane_col(plane_q)} : {fcnt_q[2:1], 2'd3};
  assign mat_rd  = mstore_q[mat_idx];
  assign pl_idx  = {plane_q, (state_q == S_TINIT) ? 2'd3 : j_q};
  assign pl_rd   = pstore_q[pl_idx];

  // Selected normal magnitude and the offset magnitude with its shifted form.
  logic [32:0]     s_sel;
  logic [32:0]     dm;
  logic [SHW-1:0]  d_wide;
  logic            d_sat;
  logic            v_neg;

  always_comb begin
    unique case (j_q)
      2'd0:    s_sel = s_q[0];
      2'd1:    s_sel = s_q[1];
      default: s_sel = s_q[2];
    endcase
  end

  assign dm     = v_q[3][32] ? (33'd0 - v_q[3]) : v_q[3];
  assign d_wide = {{(SHW-33){1'b0}}, dm} << sh_q;
  assign d_sat  = |d_wide[SHW-1:63];
  assign v_neg  = v_q[j_q][32];

  // Corner coordinate for the current term.
  logic signed [32:0] coord;

  always_comb begin
    unique case (j_q)
      2'd0:    coord = corner_q[0] ? hi_q[0] : lo_q[0];
      2'd1:    coord = corner_q[1] ? hi_q[1] : lo_q[1];
      default: coord = corner_q[2] ? hi_q[2] : lo_q[2];
    endcase
  end

  // Shared multiplier: squares during normalization, plane terms during tests.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    if (state_q == S_SQMUL) begin
      mul_a = s_sel;
      mul_b = s_sel;
    end else begin
      mul_a = {pl_rd[31], pl_rd};
      mul_b = coord;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Square root step, divider step and test helpers.
  logic [63:0]        rb;
  logic [33:0]        trial;
  logic               q_bit;
  logic signed [32:0] dsum;
  logic               pos;

  assign rb    = r_q + bit_q;
  assign trial = {rem_q, num_q[63]};
  assign q_bit = trial >= {1'b0, r_q[32:0]};
  assign dsum  = $signed({pl_rd[31], pl_rd}) + $signed({2'b00, bias_q});
  assign pos   = !acc_q[ACC_W-1] && (acc_q != '0);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    plane_d   = plane_q;
    j_d       = j_q;
    fcnt_d    = fcnt_q;
    corner_d  = corner_q;
    cnt_d     = cnt_q;
    multi_d   = multi_q;
    done_d    = 1'b0;
    inside_d  = inside_q;
    is_test_d = is_test_q;
    mat_we    = 1'b0;
    pl_we     = 1'b0;
    pl_wdata  = with_sign(num_q, v_neg);
    wr_fin    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_LOAD: begin
              mat_we    = 1'b1;
              done_d    = 1'b1;
              inside_d  = 1'b0;
              is_test_d = 1'b0;
            end
            MODE_PLANES: begin
              plane_d = 3'd0;
              fcnt_d  = 3'd0;
              state_d = S_FORM;
            end
            MODE_POINT, MODE_SPHERE, MODE_CUBE, MODE_BOX: begin
              multi_d  = (mode_i == MODE_CUBE) || (mode_i == MODE_BOX);
              plane_d  = 3'd0;
              corner_d = 3'd0;
              state_d  = S_TINIT;
            end
            default: begin
              done_d    = 1'b1;
              inside_d  = 1'b0;
              is_test_d = 1'b0;
            end
          endcase
        end
      end
      S_FORM: begin
        fcnt_d = fcnt_q + 3'd1;
        if (fcnt_q == 3'd7) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        j_d = 2'd0;
        if ((v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0)) begin
          state_d = S_DPREP;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!((|s_q[0][32:31]) || (|s_q[1][32:31]) || (|s_q[2][32:31])) &&
            (s_q[0][30] || s_q[1][30] || s_q[2][30])) begin
          j_d     = 2'd0;
          state_d = S_SQMUL;
        end
      end
      S_SQMUL: begin
        state_d = S_SQACC;
      end
      S_SQACC: begin
        if (j_q == 2'd2) begin
          state_d = S_SQRT;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_SQMUL;
        end
      end
      S_SQRT: begin
        if (bit_q == 64'd1) begin
          j_d     = 2'd0;
          state_d = S_DPREP;
        end
      end
      S_DPREP: begin
        if (zero_q) begin
          pl_we    = 1'b1;
          pl_wdata = '0;
          wr_fin   = 1'b1;
        end else if ((j_q == 2'd3) && d_sat) begin
          pl_we    = 1'b1;
          pl_wdata = with_sign({33'd0, MAG_MAX}, v_neg);
          wr_fin   = 1'b1;
        end else begin
          cnt_d   = 6'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DWR;
        end
      end
      S_DWR: begin
        pl_we  = 1'b1;
        wr_fin = 1'b1;
      end
      S_TINIT: begin
        j_d     = 2'd0;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        state_d = S_TACC;
      end
      S_TACC: begin
        if (j_q == 2'd2) begin
          state_d = S_TCHK;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_TMUL;
        end
      end
      S_TCHK: begin
        priority if (pos) begin
          if (plane_q == 3'(PLANE_COUNT - 1)) begin
            done_d    = 1'b1;
            inside_d  = 1'b1;
            is_test_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            plane_d  = plane_q + 3'd1;
            corner_d = 3'd0;
            state_d  = S_TINIT;
          end
        end else if (multi_q && (corner_q != 3'd7)) begin
          corner_d = corner_q + 3'd1;
          state_d  = S_TINIT;
        end else begin
          done_d    = 1'b1;
          inside_d  = 1'b0;
          is_test_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to the next plane word or plane after a write.
    if (wr_fin) begin
      if (j_q == 2'd3) begin
        if (plane_q == 3'(PLANE_COUNT - 1)) begin
          done_d    = 1'b1;
          inside_d  = 1'b0;
          is_test_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          plane_d = plane_q + 3'd1;
          fcnt_d  = 3'd0;
          state_d = S_FORM;
        end
      end else begin
        j_d     = j_q + 2'd1;
        state_d = S_DPREP;
      end
    end
  end

  // Control registers and the two stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      plane_q   <= '0;
      j_q       <= '0;
      fcnt_q    <= '0;
      corner_q  <= '0;
      cnt_q     <= '0;
      multi_q   <= 1'b0;
      done_q    <= 1'b0;
      inside_q  <= 1'b0;
      is_test_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        mstore_q[i] <= ((i % 5) == 0) ? FX_ONE : 32'd0;
      end
      for (int i = 0; i < 24; i++) begin
        pstore_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      plane_q   <= plane_d;
      j_q       <= j_d;
      fcnt_q    <= fcnt_d;
      corner_q  <= corner_d;
      cnt_q     <= cnt_d;
      multi_q   <= multi_d;
      done_q    <= done_d;
      inside_q  <= inside_d;
      is_test_q <= is_test_d;
      if (mat_we) begin
        mstore_q[elem_index_i] <= elem_value_i;
      end
      if (pl_we) begin
        pstore_q[pl_idx] <= pl_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        bias_q <= (mode_i == MODE_SPHERE) ? extent_i : 31'd0;
        if (mode_i == MODE_CUBE) begin
          lo_q[0] <= $signed({pos_x_i[31], pos_x_i}) - $signed({2'b00, extent_i});
          lo_q[1] <= $signed({pos_y_i[31], pos_y_i}) - $signed({2'b00, extent_i});
          lo_q[2] <= $signed({pos_z_i[31], pos_z_i}) - $signed({2'b00, extent_i});
          hi_q[0] <= $signed({pos_x_i[31], pos_x_i}) + $signed({2'b00, extent_i});
          hi_q[1] <= $signed({pos_y_i[31], pos_y_i}) + $signed({2'b00, extent_i});
          hi_q[2] <= $signed({pos_z_i[31], pos_z_i}) + $signed({2'b00, extent_i});
        end else begin
          lo_q[0] <= {pos_x_i[31], pos_x_i};
          lo_q[1] <= {pos_y_i[31], pos_y_i};
          lo_q[2] <= {pos_z_i[31], pos_z_i};
          hi_q[0] <= {far_x_i[31], far_x_i};
          hi_q[1] <= {far_y_i[31], far_y_i};
          hi_q[2] <= {far_z_i[31], far_z_i};
        end
      end
      S_FORM: begin
        if (!fcnt_q[0]) begin
          w_q <= mat_rd;
        end else if (plane_add(plane_q)) begin
          v_q[fcnt_q[2:1]] <= $signed({w_q[31], w_q}) + $signed({mat_rd[31], mat_rd});
        end else begin
          v_q[fcnt_q[2:1]] <= $signed({w_q[31], w_q}) - $signed({mat_rd[31], mat_rd});
        end
      end
      S_MAG: begin
        for (int k = 0; k < 3; k++) begin
          s_q[k] <= v_q[k][32] ? (33'd0 - v_q[k]) : v_q[k];
        end
        zero_q <= (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
        sh_q   <= SH_W'(COORD_FRAC_BITS);
        sq_n_q <= '0;
      end
      S_NORM: begin
        // Bring the largest normal component into [2^30, 2^31).
        if ((|s_q[0][32:31]) || (|s_q[1][32:31]) || (|s_q[2][32:31])) begin
          for (int k = 0; k < 3; k++) begin
            s_q[k] <= s_q[k] >> 1;
          end
          sh_q <= sh_q - SH_W'(1);
        end else if (!(s_q[0][30] || s_q[1][30] || s_q[2][30])) begin
          for (int k = 0; k < 3; k++) begin
            s_q[k] <= s_q[k] << 1;
          end
          sh_q <= sh_q + SH_W'(1);
        end
      end
      S_SQMUL, S_TMUL: begin
        prod_q <= mul_p;
      end
      S_SQACC: begin
        sq_n_q <= sq_n_q + prod_q[63:0];
        r_q    <= '0;
        bit_q  <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (sq_n_q >= rb) begin
          sq_n_q <= sq_n_q - rb;
          r_q    <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DPREP: begin
        rem_q <= '0;
        if (j_q == 2'd3) begin
          num_q <= d_wide[63:0];
        end else begin
          num_q <= {31'd0, s_sel} << 30;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit a cycle.
        if (q_bit) begin
          rem_q <= 33'(trial - {1'b0, r_q[32:0]});
        end else begin
          rem_q <= trial[32:0];
        end
        num_q <= {num_q[62:0], q_bit};
      end
      S_TINIT: begin
        acc_q <= {{(ACC_W-63){dsum[32]}}, dsum, 30'd0};
      end
      S_TACC: begin
        acc_q <= acc_q + {prod_q[65], prod_q};
      end
      default: begin
      end
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign inside_res_o = inside_q;
  assign is_test_o    = is_test_q;

  `include "view_frustum_culling_test_top_assert.svh"

  // A result never appears while a command is still in work.
  `VFC_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result transfer while busy")
  // A transferred command either answers at once or starts work.
  `VFC_ASSERT_NXT(a_start_resp, start_i && !busy_o, busy_o || done_o, "command dropped")
  // Only test answers can report inside.
  `VFC_ASSERT_IMP(a_inside_test, done_o && inside_res_o, is_test_o, "inside on non-test")

endmodule

`default_nettype wire
